### rtl/cu420_pkg.sv
// Shared types, constants and the blend function for the 4:2:0 chroma upsampler.
package cu420_pkg;

    localparam int SAMPLE_W = 16;
    localparam int WEIGHT_W = 3;
    localparam int TAP_W    = SAMPLE_W + 2;
    localparam int ACC_W    = TAP_W + WEIGHT_W + 1;
    localparam int SHIFT    = 4;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ABOVE_RST = WEIGHT_W'(3);
    localparam logic [WEIGHT_W-1:0] WEIGHT_BELOW_RST = WEIGHT_W'(1);
    localparam logic [ACC_W-1:0]    ROUND            = ACC_W'(8);

    localparam logic [1:0] FILL_EMPTY = 2'd0;
    localparam logic [1:0] FILL_ONE   = 2'd1;
    localparam logic [1:0] FILL_FULL  = 2'd2;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [WEIGHT_W-1:0] weight_t;

    typedef enum logic {
        REG_WEIGHT_ABOVE = 1'b0,
        REG_WEIGHT_BELOW = 1'b1
    } cfg_reg_e;

    typedef struct packed {
        weight_t above;
        weight_t below;
    } weights_t;

    // three-column window snapshot for one output pair
    typedef struct packed {
        sample_t prev_a;
        sample_t cur_a;
        sample_t next_a;
        sample_t prev_b;
        sample_t cur_b;
        sample_t next_b;
        logic    last;
    } operands_t;

    function automatic sample_t blend(
        input sample_t side_a,
        input sample_t cur_a,
        input sample_t side_b,
        input sample_t cur_b,
        input weight_t wa,
        input weight_t wb
    );
        logic [TAP_W-1:0] ta;
        logic [TAP_W-1:0] tb;
        logic [ACC_W-1:0] acc;
        ta  = TAP_W'(side_a) + TAP_W'({cur_a, 1'b0}) + TAP_W'(cur_a);
        tb  = TAP_W'(side_b) + TAP_W'({cur_b, 1'b0}) + TAP_W'(cur_b);
        acc = ACC_W'(ta) * ACC_W'(wa) + ACC_W'(tb) * ACC_W'(wb) + ROUND;
        return acc[SHIFT +: SAMPLE_W];
    endfunction

endpackage

### rtl/cu420_if.sv
// Stream and configuration channel interfaces of the chroma upsampler.
interface cu420_in_if;
    logic                valid;
    logic                ready;
    cu420_pkg::sample_t  above_sample;
    cu420_pkg::sample_t  below_sample;
    logic                row_start;
    logic                row_end;

    modport source (output valid, output above_sample, output below_sample,
                    output row_start, output row_end, input ready);
    modport sink   (input valid, input above_sample, input below_sample,
                    input row_start, input row_end, output ready);
endinterface

interface cu420_out_if;
    logic                valid;
    logic                ready;
    cu420_pkg::sample_t  even_sample;
    cu420_pkg::sample_t  odd_sample;
    logic                last_pair;

    modport source (output valid, output even_sample, output odd_sample,
                    output last_pair, input ready);
    modport sink   (input valid, input even_sample, input odd_sample,
                    input last_pair, output ready);
endinterface

interface cu420_cfg_if;
    logic                 valid;
    logic                 ready;
    cu420_pkg::cfg_reg_e  addr;
    cu420_pkg::weight_t   data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

### rtl/chroma_upsample_420_pairs.sv
// Top level of the 4:2:0 triangle-filter chroma upsampler.
//
// src takes one column beat of the nearer and farther chroma rows. A row is a
// left padding beat (row_start), its real columns, then a right padding beat
// (row_end). Each real column yields one dst beat holding the even and odd
// output samples; last_pair marks the final pair of a row.
// cfg writes weight_above (addr 0) and weight_below (addr 1); cfg.ready is
// always high. Write only while no beats are in flight.
// A pair is captured in the operand register when the src beat that completes
// its window is accepted, then blended into the result register that drives
// dst. Throughput is one src beat per cycle while dst does not stall.
// Reset empties the window, drops any pending results and restores weights
// of 3 (above) and 1 (below).
// A dst stall holds the result register; the operand register keeps taking
// one more pair, then src.ready falls until dst drains.
module chroma_upsample_420_pairs (
    input  logic          clk,
    input  logic          rst_n,
    cu420_in_if.sink      src,
    cu420_out_if.source   dst,
    cu420_cfg_if.sink     cfg
);

    cu420_pkg::weights_t   weights_reg, weights_next;
    logic                  op_valid;
    cu420_pkg::operands_t  op;
    logic                  op_ready;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        weights_next = weights_reg;
        if (cfg.valid)
        begin
            unique case (cfg.addr)
                cu420_pkg::REG_WEIGHT_ABOVE: weights_next.above = cfg.data;
                cu420_pkg::REG_WEIGHT_BELOW: weights_next.below = cfg.data;
                default:                     weights_next = weights_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weights_reg.above <= cu420_pkg::WEIGHT_ABOVE_RST;
            weights_reg.below <= cu420_pkg::WEIGHT_BELOW_RST;
        end
        else
        begin
            weights_reg <= weights_next;
        end
    end

    cu420_window u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .src      (src),
        .op_valid (op_valid),
        .op       (op),
        .op_ready (op_ready)
    );

    cu420_blend u_blend (
        .clk      (clk),
        .rst_n    (rst_n),
        .weights  (weights_reg),
        .op_valid (op_valid),
        .op       (op),
        .op_ready (op_ready),
        .dst      (dst)
    );

endmodule

### rtl/cu420_window.sv
// Column window tracking and operand capture register.
module cu420_window (
    input  logic                  clk,
    input  logic                  rst_n,
    cu420_in_if.sink              src,
    output logic                  op_valid,
    output cu420_pkg::operands_t  op,
    input  logic                  op_ready
);

    cu420_pkg::sample_t   prev_a_reg, prev_a_next;
    cu420_pkg::sample_t   cur_a_reg, cur_a_next;
    cu420_pkg::sample_t   prev_b_reg, prev_b_next;
    cu420_pkg::sample_t   cur_b_reg, cur_b_next;
    logic [1:0]           fill_reg, fill_next;
    logic                 op_valid_reg, op_valid_next;
    cu420_pkg::operands_t op_reg, op_next;
    logic                 accept;
    logic                 emit;

    assign src.ready = !op_valid_reg || op_ready;
    assign accept    = src.valid && src.ready;
    assign emit      = !src.row_start && (fill_reg == cu420_pkg::FILL_FULL);

    always_comb
    begin
        prev_a_next = prev_a_reg;
        cur_a_next  = cur_a_reg;
        prev_b_next = prev_b_reg;
        cur_b_next  = cur_b_reg;
        fill_next   = fill_reg;
        if (accept)
        begin
            if (src.row_start)
            begin
                prev_a_next = '0;
                prev_b_next = '0;
                fill_next   = cu420_pkg::FILL_ONE;
            end
            else
            begin
                prev_a_next = cur_a_reg;
                prev_b_next = cur_b_reg;
                if (fill_reg != cu420_pkg::FILL_FULL)
                begin
                    fill_next = fill_reg + 2'd1;
                end
            end
            cur_a_next = src.above_sample;
            cur_b_next = src.below_sample;
            if (src.row_end)
            begin
                fill_next = cu420_pkg::FILL_EMPTY;
            end
        end
    end

    always_comb
    begin
        op_valid_next  = op_valid_reg;
        op_next        = op_reg;
        if (src.ready)
        begin
            op_valid_next = accept && emit;
        end
        op_next.prev_a = prev_a_reg;
        op_next.cur_a  = cur_a_reg;
        op_next.next_a = src.above_sample;
        op_next.prev_b = prev_b_reg;
        op_next.cur_b  = cur_b_reg;
        op_next.next_b = src.below_sample;
        op_next.last   = src.row_end;
        if (!(accept && emit))
        begin
            op_next = op_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_a_reg   <= '0;
            cur_a_reg    <= '0;
            prev_b_reg   <= '0;
            cur_b_reg    <= '0;
            fill_reg     <= cu420_pkg::FILL_EMPTY;
            op_valid_reg <= 1'b0;
        end
        else
        begin
            prev_a_reg   <= prev_a_next;
            cur_a_reg    <= cur_a_next;
            prev_b_reg   <= prev_b_next;
            cur_b_reg    <= cur_b_next;
            fill_reg     <= fill_next;
            op_valid_reg <= op_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
    end

    assign op_valid = op_valid_reg;
    assign op       = op_reg;

endmodule

### rtl/cu420_blend.sv
// Weighted triangle blend of one operand set into an even/odd output pair.
module cu420_blend (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cu420_pkg::weights_t   weights,
    input  logic                  op_valid,
    input  cu420_pkg::operands_t  op,
    output logic                  op_ready,
    cu420_out_if.source           dst
);

    logic                valid_reg, valid_next;
    cu420_pkg::sample_t  even_reg, even_next;
    cu420_pkg::sample_t  odd_reg, odd_next;
    logic                last_reg, last_next;
    logic                load;

    assign op_ready = !valid_reg || dst.ready;
    assign load     = op_valid && op_ready;

    always_comb
    begin
        valid_next = valid_reg;
        even_next  = even_reg;
        odd_next   = odd_reg;
        last_next  = last_reg;
        if (op_ready)
        begin
            valid_next = op_valid;
        end
        if (load)
        begin
            even_next = cu420_pkg::blend(op.prev_a, op.cur_a, op.prev_b, op.cur_b,
                                         weights.above, weights.below);
            odd_next  = cu420_pkg::blend(op.next_a, op.cur_a, op.next_b, op.cur_b,
                                         weights.above, weights.below);
            last_next = op.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        even_reg <= even_next;
        odd_reg  <= odd_next;
        last_reg <= last_next;
    end

    assign dst.valid       = valid_reg;
    assign dst.even_sample = even_reg;
    assign dst.odd_sample  = odd_reg;
    assign dst.last_pair   = last_reg;

endmodule

### bench/cu420_pair_checker.sv
`timescale 1ns / 1ps
// Checker that predicts upsampled chroma pairs from src and cfg beats and compares dst beats.
module cu420_pair_checker
    import cu420_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    cu420_in_if   src,
    cu420_out_if  dst,
    cu420_cfg_if  cfg,
    output int    mismatches,
    output int    pairs_due
);

    typedef struct packed {
        sample_t even;
        sample_t odd;
        logic    last;
    } pair_t;

    weight_t    w_above;
    weight_t    w_below;
    sample_t    col_a [2];
    sample_t    col_b [2];
    logic [1:0] fill;
    pair_t      due_q [$];

    function automatic sample_t tri_tap(
        input sample_t side_a,
        input sample_t cur_a,
        input sample_t side_b,
        input sample_t cur_b
    );
        logic [31:0] acc;
        acc = 32'(w_above) * (32'(side_a) + 32'd3 * 32'(cur_a))
            + 32'(w_below) * (32'(side_b) + 32'd3 * 32'(cur_b)) + 32'd8;
        return acc[4 +: SAMPLE_W];
    endfunction

    // one column into the window; returns 1 when it completes a pair
    function automatic bit upsample_column(
        input  sample_t a,
        input  sample_t b,
        input  logic    start,
        input  logic    fin,
        output pair_t   pair
    );
        bit hit;
        hit  = 1'b0;
        pair = '0;
        if (start) begin
            col_a[0] = '0;
            col_b[0] = '0;
            col_a[1] = a;
            col_b[1] = b;
            fill     = FILL_ONE;
        end
        else begin
            if (fill == FILL_FULL) begin
                pair.even = tri_tap(col_a[0], col_a[1], col_b[0], col_b[1]);
                pair.odd  = tri_tap(a, col_a[1], b, col_b[1]);
                pair.last = fin;
                hit       = 1'b1;
            end
            col_a[0] = col_a[1];
            col_b[0] = col_b[1];
            col_a[1] = a;
            col_b[1] = b;
            if (fill != FILL_FULL)
                fill = fill + 2'd1;
        end
        if (fin)
            fill = FILL_EMPTY;
        return hit;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        pair_t want;
        pair_t fresh;
        if (!rst_n) begin
            w_above    = WEIGHT_ABOVE_RST;
            w_below    = WEIGHT_BELOW_RST;
            col_a[0]   = '0;
            col_a[1]   = '0;
            col_b[0]   = '0;
            col_b[1]   = '0;
            fill       = FILL_EMPTY;
            due_q.delete();
            mismatches = 0;
            pairs_due  = 0;
        end
        else begin
            if (dst.valid && dst.ready) begin
                if (due_q.size() == 0) begin
                    $display("%0t: unexpected dst beat: even %h odd %h last %b", $time,
                             dst.even_sample, dst.odd_sample, dst.last_pair);
                    mismatches++;
                end
                else begin
                    want = due_q.pop_front();
                    if (dst.even_sample !== want.even) begin
                        $display("%0t: even_sample expected %h got %h", $time,
                                 want.even, dst.even_sample);
                        mismatches++;
                    end
                    if (dst.odd_sample !== want.odd) begin
                        $display("%0t: odd_sample expected %h got %h", $time,
                                 want.odd, dst.odd_sample);
                        mismatches++;
                    end
                    if (dst.last_pair !== want.last) begin
                        $display("%0t: last_pair expected %b got %b", $time,
                                 want.last, dst.last_pair);
                        mismatches++;
                    end
                end
            end
            if (cfg.valid && cfg.ready) begin
                case (cfg.addr)
                    REG_WEIGHT_ABOVE: w_above = cfg.data;
                    REG_WEIGHT_BELOW: w_below = cfg.data;
                    default: ;
                endcase
            end
            if (src.valid && src.ready) begin
                if (upsample_column(src.above_sample, src.below_sample,
                                    src.row_start, src.row_end, fresh))
                    due_q.push_back(fresh);
            end
            pairs_due = due_q.size();
        end
    end

endmodule

### bench/tb_chroma_upsample_420_pairs.sv
`timescale 1ns / 1ps
// Testbench top: column stimulus, handshake pacing and verdict for chroma_upsample_420_pairs.
module tb_chroma_upsample_420_pairs;
    import cu420_pkg::*;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   pairs_due;
    int   send_idle_pct = 0;
    int   stall_pct     = 0;
    int   hold_left     = 0;
    int   cols_sent     = 0;

    cu420_in_if  src ();
    cu420_out_if dst ();
    cu420_cfg_if cfg ();

    chroma_upsample_420_pairs dut (
        .clk   (clk),
        .rst_n (rst_n),
        .src   (src),
        .dst   (dst),
        .cfg   (cfg)
    );

    cu420_pair_checker pair_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .src        (src),
        .dst        (dst),
        .cfg        (cfg),
        .mismatches (mismatches),
        .pairs_due  (pairs_due)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // dst.ready pacing; a long hold-off is counted down here
    initial
    begin
        dst.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                hold_left--;
                dst.ready <= 1'b0;
            end
            else begin
                dst.ready <= ($urandom_range(99, 0) >= stall_pct);
            end
        end
    end

    initial
    begin
        #4000000;
        $display("tb_chroma_upsample_420_pairs NOT OK");
        $finish;
    end

    function automatic sample_t pick_sample();
        sample_t s;
        case ($urandom_range(3, 0))
            0:       s = '0;
            1:       s = '1;
            default: s = sample_t'($urandom_range(65535, 0));
        endcase
        return s;
    endfunction

    task automatic send_col(
        input sample_t a,
        input sample_t b,
        input logic    start,
        input logic    fin
    );
        while ($urandom_range(99, 0) < send_idle_pct) begin
            src.valid <= 1'b0;
            @(negedge clk);
        end
        src.valid        <= 1'b1;
        src.above_sample <= a;
        src.below_sample <= b;
        src.row_start    <= start;
        src.row_end      <= fin;
        @(posedge clk);
        while (!src.ready)
            @(posedge clk);
        cols_sent++;
        @(negedge clk);
    endtask

    task automatic send_row(input int reals, input logic lead, input logic tail);
        if (lead)
            send_col(pick_sample(), pick_sample(), 1'b1, 1'b0);
        repeat (reals)
            send_col(pick_sample(), pick_sample(), 1'b0, 1'b0);
        if (tail)
            send_col(pick_sample(), pick_sample(), 1'b0, 1'b1);
    endtask

    // stop offering beats until every pair is out, then let the pipe settle
    task automatic drain();
        src.valid <= 1'b0;
        while (pairs_due != 0)
            @(negedge clk);
        repeat (4)
            @(negedge clk);
    endtask

    task automatic write_weight(input cfg_reg_e idx, input weight_t w);
        cfg.valid <= 1'b1;
        cfg.addr  <= idx;
        cfg.data  <= w;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        @(negedge clk);
        cfg.valid <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        int      phase_end;
        bit      held;
        bit      paused;
        weight_t wa;
        weight_t wb;
        held             = 1'b0;
        paused           = 1'b0;
        rst_n            = 1'b0;
        src.valid        = 1'b0;
        src.above_sample = '0;
        src.below_sample = '0;
        src.row_start    = 1'b0;
        src.row_end      = 1'b0;
        cfg.valid        = 1'b0;
        cfg.addr         = REG_WEIGHT_ABOVE;
        cfg.data         = '0;
        repeat (9)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // full row of extremes at reset weights
        send_col(16'h0000, 16'h0000, 1'b1, 1'b0);
        send_col(16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
        send_col(16'h0000, 16'h0000, 1'b0, 1'b0);
        send_col(16'hFFFF, 16'h0000, 1'b0, 1'b0);
        send_col(16'h0000, 16'hFFFF, 1'b0, 1'b0);
        send_col(16'hFFFF, 16'hFFFF, 1'b0, 1'b1);
        // start and end on one column
        send_col(16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
        // row with no real column
        send_col(16'h1234, 16'h5678, 1'b1, 1'b0);
        send_col(16'h9ABC, 16'hDEF0, 1'b0, 1'b1);
        // row without its start beat
        send_col(16'hFFFF, 16'h0001, 1'b0, 1'b0);
        send_col(16'h8000, 16'h7FFF, 1'b0, 1'b0);
        send_col(16'h0001, 16'hFFFE, 1'b0, 1'b0);
        send_col(16'hAAAA, 16'h5555, 1'b0, 1'b1);
        // restart in the middle of a row
        send_col(16'h0F0F, 16'hF0F0, 1'b1, 1'b0);
        send_col(16'h3333, 16'hCCCC, 1'b0, 1'b0);
        send_col(16'hFFFF, 16'h0000, 1'b0, 1'b0);
        send_col(16'h4321, 16'h8765, 1'b1, 1'b0);
        send_col(16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
        send_col(16'h0000, 16'hFFFF, 1'b0, 1'b1);

        // top weights: sums overflow 16 bits
        drain();
        write_weight(REG_WEIGHT_ABOVE, 3'd7);
        write_weight(REG_WEIGHT_BELOW, 3'd7);
        send_col(16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
        send_col(16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
        send_col(16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
        send_col(16'hFFFF, 16'hFFFF, 1'b0, 1'b1);

        for (int phase = 0; phase < 6; phase++) begin
            drain();
            case (phase)
                0: begin wa = 3'd0; wb = 3'd0; end
                1: begin wa = 3'd4; wb = 3'd4; end
                2: begin wa = 3'd7; wb = 3'd0; end
                3: begin wa = 3'd0; wb = 3'd7; end
                default: begin
                    wa = weight_t'($urandom_range(7, 0));
                    wb = weight_t'($urandom_range(7, 0));
                end
            endcase
            write_weight(REG_WEIGHT_ABOVE, wa);
            write_weight(REG_WEIGHT_BELOW, wb);
            case (phase % 4)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 73; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 73; end
                default: begin send_idle_pct = 12; stall_pct = 12; end
            endcase
            phase_end = cols_sent + 90;
            while (cols_sent < phase_end) begin
                if (phase == 4 && !held && cols_sent >= phase_end - 70) begin
                    hold_left = 200;
                    held      = 1'b1;
                end
                if (phase == 1 && !paused && cols_sent >= phase_end - 45) begin
                    drain();
                    paused = 1'b1;
                end
                case ($urandom_range(19, 0))
                    0, 1:
                        send_col(pick_sample(), pick_sample(),
                                 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
                    2: send_row($urandom_range(6, 0), 1'b0, 1'b1);
                    3: send_row($urandom_range(6, 0), 1'b1, 1'b0);
                    default:
                        send_row(($urandom_range(9, 0) == 0) ? $urandom_range(40, 10)
                                                             : $urandom_range(6, 1),
                                 1'b1, 1'b1);
                endcase
            end
        end

        drain();
        if (mismatches == 0 && pairs_due == 0)
            $display("tb_chroma_upsample_420_pairs OK");
        else
            $display("tb_chroma_upsample_420_pairs NOT OK");
        $finish;
    end

endmodule
